>>> rtl/oal_pkg.sv
// package: shared constants, types and codes of the ordered array list engine
`timescale 1ns / 1ps
`default_nettype none
package oal_pkg;

   localparam int CAPACITY = 64;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = 7;
   localparam int POS_W    = 7;
   localparam int VAL_W    = 8;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_DELETE = 2'd1,
      OP_GET    = 2'd2,
      OP_LOCATE = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_BAD_POS   = 2'd1,
      STAT_FULL      = 2'd2,
      STAT_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_FIND
   } state_type;

   // command broadcast to every cell
   typedef struct packed {
      opcode_type       op;
      logic [POS_W-1:0] slot;
      logic [VAL_W-1:0] value;
      logic [CNT_W-1:0] count;
      logic             shift_en;
   } cell_cmd_type;

   // per-cell contribution to the read-out trees
   typedef struct packed {
      logic [VAL_W-1:0] rd_data;
      logic [VAL_W-1:0] prior_data;
      logic [VAL_W-1:0] next_data;
      logic             next_hit;
   } cell_tap_type;

   typedef struct packed {
      status_type       status;
      logic [VAL_W-1:0] data_out;
      logic [CNT_W-1:0] found_position;
      logic [VAL_W-1:0] prior_value;
      logic             prior_valid;
      logic [VAL_W-1:0] next_value;
      logic             next_valid;
      logic [CNT_W-1:0] list_count;
   } rsp_type;

endpackage
`default_nettype wire

>>> rtl/oal_req_if.sv
// interface: request channel carrying one list operation
`timescale 1ns / 1ps
`default_nettype none
interface oal_req_if;
   logic                     valid;
   logic                     ready;
   logic [1:0]               opcode;
   logic [oal_pkg::POS_W-1:0] position;
   logic [oal_pkg::VAL_W-1:0] element_value;

   modport source (output valid, output opcode, output position, output element_value,
                   input ready);
   modport sink   (input valid, input opcode, input position, input element_value,
                   output ready);
endinterface
`default_nettype wire

>>> rtl/oal_rsp_if.sv
// interface: response channel carrying one operation result
`timescale 1ns / 1ps
`default_nettype none
interface oal_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [1:0]                status;
   logic [oal_pkg::VAL_W-1:0] data_out;
   logic [oal_pkg::CNT_W-1:0] found_position;
   logic [oal_pkg::VAL_W-1:0] prior_value;
   logic                      prior_valid;
   logic [oal_pkg::VAL_W-1:0] next_value;
   logic                      next_valid;
   logic [oal_pkg::CNT_W-1:0] list_count;

   modport source (output valid, output status, output data_out, output found_position,
                   output prior_value, output prior_valid, output next_value,
                   output next_valid, output list_count, input ready);
   modport sink   (input valid, input status, input data_out, input found_position,
                   input prior_value, input prior_valid, input next_value,
                   input next_valid, input list_count, output ready);
endinterface
`default_nettype wire

>>> rtl/oal_cell.sv
// module: one list cell holding an entry, shifting with its neighbors and matching
`timescale 1ns / 1ps
`default_nettype none
module oal_cell (
   input  wire logic                       clock,
   input  wire logic [oal_pkg::IDX_W-1:0]  cell_index,
   input  wire oal_pkg::cell_cmd_type      cmd,
   input  wire logic [oal_pkg::VAL_W-1:0]  left_data,
   input  wire logic [oal_pkg::VAL_W-1:0]  right_data,
   input  wire logic                       first_left,
   input  wire logic                       first_right,
   output logic      [oal_pkg::VAL_W-1:0]  data,
   output logic                            match,
   output oal_pkg::cell_tap_type           tap
);

   logic [oal_pkg::VAL_W-1:0] data_ff, data_in;
   logic                      match_ff, match_in;
   logic [oal_pkg::CNT_W-1:0] idx;
   logic                      occupied;
   logic                      at_slot;
   logic                      past_slot;

   assign idx       = oal_pkg::CNT_W'(cell_index);
   assign occupied  = idx < cmd.count;
   assign at_slot   = idx == cmd.slot;
   assign past_slot = idx > cmd.slot;

   always_comb begin
      data_in = data_ff;
      if (cmd.shift_en) begin
         case (cmd.op)
            oal_pkg::OP_INSERT: begin
               if (past_slot) begin
                  data_in = left_data;
               end else if (at_slot) begin
                  data_in = cmd.value;
               end
            end
            oal_pkg::OP_DELETE: begin
               if (past_slot || at_slot) begin
                  data_in = right_data;
               end
            end
            default: begin
               data_in = data_ff;
            end
         endcase
      end
   end

   assign match_in = occupied && (data_ff == cmd.value);

   always_ff @(posedge clock) begin
      data_ff  <= data_in;
      match_ff <= match_in;
   end

   assign data  = data_ff;
   assign match = match_ff;

   // read-out contributions, zero unless selected
   assign tap.rd_data    = at_slot ? data_ff : '0;
   assign tap.prior_data = first_right ? data_ff : '0;
   assign tap.next_hit   = first_left && occupied;
   assign tap.next_data  = (first_left && occupied) ? data_ff : '0;

endmodule
`default_nettype wire

>>> rtl/oal_row.sv
// module: row of list cells with neighbor links and or-reduced read-out
`timescale 1ns / 1ps
`default_nettype none
module oal_row (
   input  wire logic                          clock,
   input  wire oal_pkg::cell_cmd_type         cmd,
   output logic      [oal_pkg::CAPACITY-1:0]  match_vec,
   output logic      [oal_pkg::VAL_W-1:0]     rd_data,
   output logic      [oal_pkg::VAL_W-1:0]     prior_data,
   output logic      [oal_pkg::VAL_W-1:0]     next_data,
   output logic                               next_hit,
   output logic      [oal_pkg::CNT_W-1:0]     found_position
);

   logic [oal_pkg::VAL_W-1:0]    cell_data [oal_pkg::CAPACITY];
   oal_pkg::cell_tap_type        taps      [oal_pkg::CAPACITY];
   logic [oal_pkg::CAPACITY-1:0] first_vec;

   // lowest set match flag
   assign first_vec = match_vec & (~match_vec + oal_pkg::CAPACITY'(1));

   for (genvar i = 0; i < oal_pkg::CAPACITY; i++) begin : g_cell
      logic [oal_pkg::VAL_W-1:0] left_d;
      logic [oal_pkg::VAL_W-1:0] right_d;
      logic                      first_l;
      logic                      first_r;

      if (i == 0) begin : g_lo
         assign left_d  = '0;
         assign first_l = 1'b0;
      end else begin : g_lo
         assign left_d  = cell_data[i-1];
         assign first_l = first_vec[i-1];
      end

      if (i == oal_pkg::CAPACITY - 1) begin : g_hi
         assign right_d = '0;
         assign first_r = 1'b0;
      end else begin : g_hi
         assign right_d = cell_data[i+1];
         assign first_r = first_vec[i+1];
      end

      oal_cell u_cell (
         .clock       (clock),
         .cell_index  (oal_pkg::IDX_W'(i)),
         .cmd         (cmd),
         .left_data   (left_d),
         .right_data  (right_d),
         .first_left  (first_l),
         .first_right (first_r),
         .data        (cell_data[i]),
         .match       (match_vec[i]),
         .tap         (taps[i])
      );
   end

   always_comb begin
      rd_data        = '0;
      prior_data     = '0;
      next_data      = '0;
      next_hit       = 1'b0;
      found_position = '0;
      for (int i = 0; i < oal_pkg::CAPACITY; i++) begin
         rd_data    = rd_data | taps[i].rd_data;
         prior_data = prior_data | taps[i].prior_data;
         next_data  = next_data | taps[i].next_data;
         next_hit   = next_hit | taps[i].next_hit;
         if (first_vec[i]) begin
            found_position = found_position | oal_pkg::CNT_W'(i + 1);
         end
      end
   end

endmodule
`default_nettype wire

>>> rtl/ordered_array_list_engine_unit.sv
// top level: ordered byte list engine built on a shifting row of cells
// insert, delete, get: S_EXEC registers the result once the output register is free, then back to idle
// locate: S_EXEC, then S_FIND registers the result once the output register is free; ready only in idle
// the extra locate state lets the per-cell match flags register before the first-match pick
// a new request is taken while the previous result still waits in the output register
// reset empties the list, sets the capacity limit to 64 and holds ready low; cells not cleared
`timescale 1ns / 1ps
`default_nettype none
module ordered_array_list_engine_unit (
   input  wire logic                      clock,
   input  wire logic                      reset,
   oal_req_if.sink                        req,
   oal_rsp_if.source                      rsp,
   input  wire logic                      csr_write_enable,
   input  wire logic [oal_pkg::CNT_W-1:0] csr_write_data
);

   oal_pkg::state_type        state_ff, state_in;
   logic [oal_pkg::CNT_W-1:0] limit_ff;
   logic [oal_pkg::CNT_W-1:0] count_ff, count_in;
   oal_pkg::opcode_type       op_ff;
   logic [oal_pkg::POS_W-1:0] pos_ff;
   logic [oal_pkg::VAL_W-1:0] value_ff;
   oal_pkg::rsp_type          rsp_ff, rsp_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   logic                         accept;
   logic                         slot_free;
   logic                         exec_commit;
   logic                         find_commit;
   logic [oal_pkg::CNT_W-1:0]    lim;
   logic                         ins_bad;
   logic                         rd_bad;
   logic                         full;
   oal_pkg::status_type          exec_status;
   oal_pkg::rsp_type             exec_res;
   oal_pkg::rsp_type             find_res;
   oal_pkg::cell_cmd_type        cmd;
   logic [oal_pkg::CAPACITY-1:0] match_vec;
   logic [oal_pkg::VAL_W-1:0]    rd_data;
   logic [oal_pkg::VAL_W-1:0]    prior_data;
   logic [oal_pkg::VAL_W-1:0]    next_data;
   logic                         next_hit;
   logic [oal_pkg::CNT_W-1:0]    found_position;
   logic                         any_match;

   assign accept    = req.valid && req.ready;
   assign slot_free = !rsp_valid_ff || rsp.ready;

   // position and fullness checks
   assign lim     = (limit_ff > oal_pkg::CNT_W'(oal_pkg::CAPACITY)) ?
                    oal_pkg::CNT_W'(oal_pkg::CAPACITY) : limit_ff;
   assign ins_bad = (pos_ff == '0) || (pos_ff > (count_ff + oal_pkg::CNT_W'(1)));
   assign rd_bad  = (pos_ff == '0) || (pos_ff > count_ff);
   assign full    = count_ff >= lim;

   always_comb begin
      case (op_ff)
         oal_pkg::OP_INSERT: begin
            if (ins_bad) begin
               exec_status = oal_pkg::STAT_BAD_POS;
            end else if (full) begin
               exec_status = oal_pkg::STAT_FULL;
            end else begin
               exec_status = oal_pkg::STAT_OK;
            end
         end
         oal_pkg::OP_DELETE, oal_pkg::OP_GET: begin
            exec_status = rd_bad ? oal_pkg::STAT_BAD_POS : oal_pkg::STAT_OK;
         end
         default: begin
            exec_status = oal_pkg::STAT_NOT_FOUND;
         end
      endcase
   end

   assign cmd.op       = op_ff;
   assign cmd.slot     = pos_ff - oal_pkg::POS_W'(1);
   assign cmd.value    = value_ff;
   assign cmd.count    = count_ff;
   assign cmd.shift_en = exec_commit && (exec_status == oal_pkg::STAT_OK) &&
                         ((op_ff == oal_pkg::OP_INSERT) || (op_ff == oal_pkg::OP_DELETE));

   oal_row u_row (
      .clock          (clock),
      .cmd            (cmd),
      .match_vec      (match_vec),
      .rd_data        (rd_data),
      .prior_data     (prior_data),
      .next_data      (next_data),
      .next_hit       (next_hit),
      .found_position (found_position)
   );

   always_comb begin
      count_in = count_ff;
      if (cmd.shift_en) begin
         if (op_ff == oal_pkg::OP_INSERT) begin
            count_in = count_ff + oal_pkg::CNT_W'(1);
         end else begin
            count_in = count_ff - oal_pkg::CNT_W'(1);
         end
      end
   end

   always_comb begin
      exec_res                = '0;
      exec_res.status         = exec_status;
      exec_res.list_count     = count_in;
      if (((op_ff == oal_pkg::OP_DELETE) || (op_ff == oal_pkg::OP_GET)) && !rd_bad) begin
         exec_res.data_out = rd_data;
      end
   end

   assign any_match = |match_vec;

   always_comb begin
      find_res                = '0;
      find_res.status         = any_match ? oal_pkg::STAT_OK : oal_pkg::STAT_NOT_FOUND;
      find_res.found_position = found_position;
      find_res.prior_value    = prior_data;
      find_res.prior_valid    = any_match && !match_vec[0];
      find_res.next_value     = next_data;
      find_res.next_valid     = next_hit;
      find_res.list_count     = count_ff;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         oal_pkg::S_IDLE: begin
            if (accept) begin
               state_in = oal_pkg::S_EXEC;
            end
         end
         oal_pkg::S_EXEC: begin
            if (op_ff == oal_pkg::OP_LOCATE) begin
               state_in = oal_pkg::S_FIND;
            end else if (slot_free) begin
               state_in = oal_pkg::S_IDLE;
            end
         end
         oal_pkg::S_FIND: begin
            if (slot_free) begin
               state_in = oal_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = oal_pkg::S_IDLE;
         end
      endcase
   end

   // state outputs
   always_comb begin
      req.ready   = 1'b0;
      exec_commit = 1'b0;
      find_commit = 1'b0;
      case (state_ff)
         oal_pkg::S_IDLE: begin
            req.ready = !reset;
         end
         oal_pkg::S_EXEC: begin
            exec_commit = (op_ff != oal_pkg::OP_LOCATE) && slot_free;
         end
         oal_pkg::S_FIND: begin
            find_commit = slot_free;
         end
         default: begin
            req.ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (exec_commit) begin
         rsp_in       = exec_res;
         rsp_valid_in = 1'b1;
      end else if (find_commit) begin
         rsp_in       = find_res;
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= oal_pkg::S_IDLE;
         limit_ff     <= oal_pkg::CNT_W'(oal_pkg::CAPACITY);
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            limit_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (accept) begin
         op_ff    <= oal_pkg::opcode_type'(req.opcode);
         pos_ff   <= req.position;
         value_ff <= req.element_value;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.status         = rsp_ff.status;
   assign rsp.data_out       = rsp_ff.data_out;
   assign rsp.found_position = rsp_ff.found_position;
   assign rsp.prior_value    = rsp_ff.prior_value;
   assign rsp.prior_valid    = rsp_ff.prior_valid;
   assign rsp.next_value     = rsp_ff.next_value;
   assign rsp.next_valid     = rsp_ff.next_valid;
   assign rsp.list_count     = rsp_ff.list_count;

endmodule
`default_nettype wire

>>> verif/tb_ordered_array_list_engine_unit.sv
// testbench: ordered array list engine checked against a behavioral list predictor
`timescale 1ns / 1ps
module tb_ordered_array_list_engine_unit;

   localparam int DIR_N = 28;

   typedef struct packed {
      logic                      set_cap;
      logic [oal_pkg::CNT_W-1:0] cap_value;
      oal_pkg::opcode_type       op;
      logic [oal_pkg::POS_W-1:0] pos;
      logic [oal_pkg::VAL_W-1:0] val;
      logic                      typed;
      oal_pkg::status_type       t_status;
      logic [oal_pkg::VAL_W-1:0] t_data;
      logic [oal_pkg::CNT_W-1:0] t_count;
   } list_step_type;

   logic                      clock;
   logic                      reset;
   logic                      csr_write_enable;
   logic [oal_pkg::CNT_W-1:0] csr_write_data;

   oal_req_if req_ch ();
   oal_rsp_if rsp_ch ();

   ordered_array_list_engine_unit uut (
      .clock            (clock),
      .reset            (reset),
      .req              (req_ch),
      .rsp              (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // predicted list contents and limit
   logic [oal_pkg::VAL_W-1:0] list_mem [oal_pkg::CAPACITY];
   int                        list_len;
   logic [oal_pkg::CNT_W-1:0] cap_reg;
   oal_pkg::rsp_type          pending_rsp_q [$];
   int                        error_count;
   logic                      steady_flow;
   int                        sink_hold;
   logic                      sink_on;

   list_step_type dir_plan [DIR_N] = '{
      '{1'b0, 7'd0,   oal_pkg::OP_GET,    7'd1,   8'h00, 1'b1, oal_pkg::STAT_BAD_POS,
        8'h00, 7'd0},
      '{1'b0, 7'd0,   oal_pkg::OP_DELETE, 7'd0,   8'h00, 1'b1, oal_pkg::STAT_BAD_POS,
        8'h00, 7'd0},
      '{1'b0, 7'd0,   oal_pkg::OP_LOCATE, 7'd0,   8'h00, 1'b1, oal_pkg::STAT_NOT_FOUND,
        8'h00, 7'd0},
      '{1'b0, 7'd0,   oal_pkg::OP_INSERT, 7'd0,   8'hFF, 1'b1, oal_pkg::STAT_BAD_POS,
        8'h00, 7'd0},
      '{1'b0, 7'd0,   oal_pkg::OP_INSERT, 7'd2,   8'h12, 1'b1, oal_pkg::STAT_BAD_POS,
        8'h00, 7'd0},
      '{1'b0, 7'd0,   oal_pkg::OP_INSERT, 7'd1,   8'hFF, 1'b1, oal_pkg::STAT_OK,
        8'h00, 7'd1},
      '{1'b0, 7'd0,   oal_pkg::OP_INSERT, 7'd1,   8'h00, 1'b1, oal_pkg::STAT_OK,
        8'h00, 7'd2},
      '{1'b0, 7'd0,   oal_pkg::OP_INSERT, 7'd3,   8'h5A, 1'b1, oal_pkg::STAT_OK,
        8'h00, 7'd3},
      '{1'b0, 7'd0,   oal_pkg::OP_INSERT, 7'd127, 8'hA5, 1'b1, oal_pkg::STAT_BAD_POS,
        8'h00, 7'd3},
      '{1'b0, 7'd0,   oal_pkg::OP_GET,    7'd1,   8'h00, 1'b1, oal_pkg::STAT_OK,
        8'h00, 7'd3},
      '{1'b0, 7'd0,   oal_pkg::OP_GET,    7'd3,   8'h00, 1'b1, oal_pkg::STAT_OK,
        8'h5A, 7'd3},
      '{1'b0, 7'd0,   oal_pkg::OP_GET,    7'd4,   8'h00, 1'b1, oal_pkg::STAT_BAD_POS,
        8'h00, 7'd3},
      '{1'b0, 7'd0,   oal_pkg::OP_LOCATE, 7'd0,   8'hFF, 1'b0, oal_pkg::STAT_OK,
        8'h00, 7'd0},
      '{1'b0, 7'd0,   oal_pkg::OP_LOCATE, 7'd0,   8'h00, 1'b0, oal_pkg::STAT_OK,
        8'h00, 7'd0},
      '{1'b0, 7'd0,   oal_pkg::OP_LOCATE, 7'd0,   8'h5A, 1'b0, oal_pkg::STAT_OK,
        8'h00, 7'd0},
      '{1'b0, 7'd0,   oal_pkg::OP_LOCATE, 7'd0,   8'h77, 1'b1, oal_pkg::STAT_NOT_FOUND,
        8'h00, 7'd3},
      '{1'b0, 7'd0,   oal_pkg::OP_INSERT, 7'd2,   8'hFF, 1'b0, oal_pkg::STAT_OK,
        8'h00, 7'd0},
      '{1'b0, 7'd0,   oal_pkg::OP_LOCATE, 7'd0,   8'hFF, 1'b0, oal_pkg::STAT_OK,
        8'h00, 7'd0},
      '{1'b0, 7'd0,   oal_pkg::OP_DELETE, 7'd127, 8'h00, 1'b1, oal_pkg::STAT_BAD_POS,
        8'h00, 7'd4},
      '{1'b0, 7'd0,   oal_pkg::OP_DELETE, 7'd4,   8'h00, 1'b0, oal_pkg::STAT_OK,
        8'h00, 7'd0},
      '{1'b0, 7'd0,   oal_pkg::OP_DELETE, 7'd1,   8'h00, 1'b0, oal_pkg::STAT_OK,
        8'h00, 7'd0},
      '{1'b0, 7'd0,   oal_pkg::OP_GET,    7'd0,   8'h00, 1'b1, oal_pkg::STAT_BAD_POS,
        8'h00, 7'd2},
      '{1'b1, 7'd1,   oal_pkg::OP_INSERT, 7'd1,   8'h33, 1'b1, oal_pkg::STAT_FULL,
        8'h00, 7'd2},
      '{1'b0, 7'd0,   oal_pkg::OP_INSERT, 7'd4,   8'h33, 1'b1, oal_pkg::STAT_BAD_POS,
        8'h00, 7'd2},
      '{1'b0, 7'd0,   oal_pkg::OP_DELETE, 7'd2,   8'h00, 1'b0, oal_pkg::STAT_OK,
        8'h00, 7'd0},
      '{1'b0, 7'd0,   oal_pkg::OP_DELETE, 7'd1,   8'h00, 1'b0, oal_pkg::STAT_OK,
        8'h00, 7'd0},
      '{1'b1, 7'd0,   oal_pkg::OP_INSERT, 7'd1,   8'h80, 1'b1, oal_pkg::STAT_FULL,
        8'h00, 7'd0},
      '{1'b1, 7'd127, oal_pkg::OP_INSERT, 7'd1,   8'h80, 1'b0, oal_pkg::STAT_OK,
        8'h00, 7'd0}
   };

   function automatic oal_pkg::rsp_type apply_list_op(
         input oal_pkg::opcode_type       op,
         input logic [oal_pkg::POS_W-1:0] pos,
         input logic [oal_pkg::VAL_W-1:0] val);
      oal_pkg::rsp_type r;
      int               lim;
      int               p;
      int               k;
      r   = '0;
      p   = int'(pos);
      lim = (int'(cap_reg) > oal_pkg::CAPACITY) ? oal_pkg::CAPACITY : int'(cap_reg);
      case (op)
         oal_pkg::OP_INSERT: begin
            if (p < 1 || p > list_len + 1) begin
               r.status = oal_pkg::STAT_BAD_POS;
            end else if (list_len >= lim) begin
               r.status = oal_pkg::STAT_FULL;
            end else begin
               for (k = list_len; k >= p; k--) list_mem[k] = list_mem[k-1];
               list_mem[p-1] = val;
               list_len++;
            end
         end
         oal_pkg::OP_DELETE: begin
            if (p < 1 || p > list_len) begin
               r.status = oal_pkg::STAT_BAD_POS;
            end else begin
               r.data_out = list_mem[p-1];
               for (k = p; k < list_len; k++) list_mem[k-1] = list_mem[k];
               list_len--;
            end
         end
         oal_pkg::OP_GET: begin
            if (p < 1 || p > list_len) r.status = oal_pkg::STAT_BAD_POS;
            else r.data_out = list_mem[p-1];
         end
         default: begin
            r.status = oal_pkg::STAT_NOT_FOUND;
            for (k = 0; k < list_len; k++) begin
               if (list_mem[k] == val) begin
                  r.status         = oal_pkg::STAT_OK;
                  r.found_position = oal_pkg::CNT_W'(k + 1);
                  if (k > 0) begin
                     r.prior_value = list_mem[k-1];
                     r.prior_valid = 1'b1;
                  end
                  if (k + 1 < list_len) begin
                     r.next_value = list_mem[k+1];
                     r.next_valid = 1'b1;
                  end
                  break;
               end
            end
         end
      endcase
      r.list_count = oal_pkg::CNT_W'(list_len);
      return r;
   endfunction

   // mostly no pause, some short, a few long
   function automatic int random_pause();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic oal_pkg::opcode_type pick_op(input int ins_pct);
      int r;
      r = $urandom_range(0, 99);
      if (r < ins_pct) return oal_pkg::OP_INSERT;
      r = $urandom_range(0, 2);
      return (r == 0) ? oal_pkg::OP_DELETE : (r == 1) ? oal_pkg::OP_GET : oal_pkg::OP_LOCATE;
   endfunction

   function automatic logic [oal_pkg::POS_W-1:0] pick_pos(input int hi);
      int r;
      r = $urandom_range(0, 99);
      if (r < 80 && hi >= 1) return oal_pkg::POS_W'($urandom_range(1, hi));
      if (r < 87) return '0;
      if (r < 94) return oal_pkg::POS_W'(hi + 1);
      return oal_pkg::POS_W'($urandom_range(0, 127));
   endfunction

   task automatic check_field(input string field, input logic [7:0] want_v,
                              input logic [7:0] got_v);
      if (got_v !== want_v) begin
         $display("%0t %s mismatch: expected %0h actual %0h", $time, field, want_v, got_v);
         error_count++;
      end
   endtask

   task automatic set_capacity(input logic [oal_pkg::CNT_W-1:0] value);
      req_ch.valid <= 1'b0;
      while (pending_rsp_q.size() != 0) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cap_reg = value;
   endtask

   task automatic issue_request(input list_step_type row);
      int               gap;
      oal_pkg::rsp_type want;
      gap = steady_flow ? 0 : random_pause();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.opcode        <= row.op;
      req_ch.position      <= row.pos;
      req_ch.element_value <= row.val;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      want = apply_list_op(row.op, row.pos, row.val);
      if (row.typed) begin
         want.status     = row.t_status;
         want.data_out   = row.t_data;
         want.list_count = row.t_count;
      end
      pending_rsp_q.push_back(want);
   endtask

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   // sink side stalls
   always @(posedge clock) begin
      if (sink_hold > 0) begin
         sink_hold = sink_hold - 1;
      end else begin
         sink_on = !sink_on;
         if (sink_on) begin
            sink_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150)
                                                   : $urandom_range(0, 10);
         end else begin
            sink_hold = random_pause();
         end
         rsp_ch.ready <= sink_on;
      end
   end

   // result checking
   always @(posedge clock) begin
      oal_pkg::rsp_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (pending_rsp_q.size() == 0) begin
            $display("%0t unexpected transaction: expected none, actual status %0h count %0h",
                     $time, rsp_ch.status, rsp_ch.list_count);
            error_count++;
         end else begin
            want = pending_rsp_q.pop_front();
            check_field("status", 8'(want.status), 8'(rsp_ch.status));
            check_field("data_out", want.data_out, rsp_ch.data_out);
            check_field("found_position", 8'(want.found_position),
                        8'(rsp_ch.found_position));
            check_field("prior_value", want.prior_value, rsp_ch.prior_value);
            check_field("prior_valid", 8'(want.prior_valid), 8'(rsp_ch.prior_valid));
            check_field("next_value", want.next_value, rsp_ch.next_value);
            check_field("next_valid", 8'(want.next_valid), 8'(rsp_ch.next_valid));
            check_field("list_count", 8'(want.list_count), 8'(rsp_ch.list_count));
         end
      end
   end

   initial begin
      list_step_type row;
      int            i;
      int            ph;
      int            n;
      int            ins_pct;
      int            cap;
      reset                = 1'b1;
      csr_write_enable     = 1'b0;
      csr_write_data       = '0;
      req_ch.valid         = 1'b0;
      req_ch.opcode        = '0;
      req_ch.position      = '0;
      req_ch.element_value = '0;
      rsp_ch.ready         = 1'b0;
      sink_hold            = 0;
      sink_on              = 1'b0;
      list_len             = 0;
      cap_reg              = 7'd64;
      error_count          = 0;
      steady_flow          = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < DIR_N; i++) begin
         if (dir_plan[i].set_cap) set_capacity(dir_plan[i].cap_value);
         issue_request(dir_plan[i]);
      end

      for (ph = 0; ph < 9; ph++) begin
         case (ph)
            0: begin cap = 64;  ins_pct = 75; n = 220; end
            1: begin cap = 127; ins_pct = 45; n = 100; end
            2: begin cap = 10;  ins_pct = 20; n = 120; end
            3: begin cap = 0;   ins_pct = 50; n = 40;  end
            4: begin cap = 1;   ins_pct = 50; n = 60;  end
            default: begin
               cap     = $urandom_range(1, 64);
               ins_pct = $urandom_range(30, 65);
               n       = 60;
            end
         endcase
         steady_flow = (ph == 1 || ph == 5);
         set_capacity(oal_pkg::CNT_W'(cap));
         for (i = 0; i < n; i++) begin
            row    = '0;
            row.op = pick_op(ins_pct);
            case (row.op)
               oal_pkg::OP_INSERT: begin
                  row.pos = pick_pos(list_len + 1);
                  row.val = ($urandom_range(0, 3) == 0) ?
                            oal_pkg::VAL_W'($urandom_range(0, 3)) :
                            oal_pkg::VAL_W'($urandom_range(0, 255));
               end
               oal_pkg::OP_LOCATE: begin
                  row.pos = oal_pkg::POS_W'($urandom_range(0, 127));
                  if (list_len > 0 && $urandom_range(0, 9) < 6)
                     row.val = list_mem[$urandom_range(0, list_len - 1)];
                  else
                     row.val = oal_pkg::VAL_W'($urandom_range(0, 255));
               end
               default: begin
                  row.pos = pick_pos(list_len);
                  row.val = oal_pkg::VAL_W'($urandom_range(0, 255));
               end
            endcase
            issue_request(row);
         end
      end

      req_ch.valid <= 1'b0;
      while (pending_rsp_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
